// File: hdl/postfix_to_accumulator_code_assert.svh
// Assertion macros for the postfix code generator
`ifndef POSTFIX_TO_ACCUMULATOR_CODE_ASSERT_SVH
`define POSTFIX_TO_ACCUMULATOR_CODE_ASSERT_SVH

// same-cycle implication
`define PFAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pfac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfac_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam int BURST_LEN = 3;

	typedef enum logic [2:0] {
		OP_LDA = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_STA = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       first;
	} sym_word_t;

	typedef struct packed {
		opcode_t    opcode;
		logic       operand_is_temp;
		logic [7:0] operand_value;
		status_t    status;
		logic       last;
	} code_word_t;

	typedef struct packed {
		logic       is_temp;
		logic [7:0] value;
	} entry_t;

	typedef struct packed {
		logic take_prev;
		logic take_next;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/postfix_to_accumulator_code.sv
`timescale 1ns / 1ps
`default_nettype none
// Postfix to single-accumulator code generator. Each symbol word is one
// expression character; an operand is taken at once and yields no code
// word, and it is taken even while earlier code words still drain. An
// operator yields LDA left, op right, STA Tn as three code words, one per
// cycle on the single output channel when the output does not stall; a
// stack underflow or overflow yields one status word. The next word-producing
// symbol is taken in the cycle the last word of the previous burst leaves.
// The operand stack is a row of shift cells, top entry in cell zero.
module postfix_to_accumulator_code
	import pfac_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        sym_valid,
	output logic       sym_stall,
	input  sym_word_t  sym_word,
	output logic       code_valid,
	input  wire        code_stall,
	output code_word_t code_word
);

`include "postfix_to_accumulator_code_assert.svh"

	logic [DEPTH_W-1:0] depth_q;
	logic [7:0]         tc_q;

	logic [DEPTH_W-1:0] depth_eff;
	logic [7:0]         tc_eff;
	logic [7:0]         tc_new;
	logic               is_op;
	opcode_t            op_code;
	logic               under;
	logic               over;
	logic               has_words;
	logic               fire;
	logic               push;
	logic               comb;
	logic               free;
	entry_t             top_new;
	entry_t             ent [STACK_DEPTH];
	code_word_t         burst [BURST_LEN];
	logic [1:0]         burst_cnt;

	assign depth_eff = sym_word.first ? '0 : depth_q;
	assign tc_eff = sym_word.first ? 8'd0 : tc_q;
	assign tc_new = tc_eff + 8'd1;

	always_comb begin
		is_op = 1'b1;
		op_code = OP_ADD;
		unique case (sym_word.symbol)
			CH_PLUS:  op_code = OP_ADD;
			CH_MINUS: op_code = OP_SUB;
			CH_STAR:  op_code = OP_MUL;
			CH_SLASH: op_code = OP_DIV;
			default:  is_op = 1'b0;
		endcase
	end

	assign under = is_op && (depth_eff < DEPTH_W'(2));
	assign over = !is_op && (depth_eff == DEPTH_W'(STACK_DEPTH));
	assign has_words = is_op || over;

	assign sym_stall = has_words && !free;
	assign fire = sym_valid && !sym_stall;
	assign push = fire && !is_op && !over;
	assign comb = fire && is_op && !under;

	assign top_new = is_op ? entry_t'{is_temp: 1'b1, value: tc_new}
	                       : entry_t'{is_temp: 1'b0, value: sym_word.symbol};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			tc_q <= 8'd0;
		end else if (fire) begin
			tc_q <= comb ? tc_new : tc_eff;
			if (push) begin
				depth_q <= depth_eff + DEPTH_W'(1);
			end else if (comb) begin
				depth_q <= depth_eff - DEPTH_W'(1);
			end else begin
				depth_q <= depth_eff;
			end
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     prev;
		entry_t     next;

		if (i == 0) begin : g_head
			assign ctrl.take_prev = push || comb;
			assign ctrl.take_next = 1'b0;
			assign prev = top_new;
		end else begin : g_body
			assign ctrl.take_prev = push;
			assign ctrl.take_next = comb;
			assign prev = ent[i - 1];
		end

		if (i == STACK_DEPTH - 1) begin : g_tail
			assign next = '0;
		end else begin : g_link
			assign next = ent[i + 1];
		end

		pfac_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.prev  (prev),
			.next  (next),
			.entry (ent[i])
		);
	end

	always_comb begin
		if (under || over) begin
			burst[0] = '{opcode: OP_LDA, operand_is_temp: 1'b0, operand_value: 8'd0,
			             status: (under ? ST_UNDER : ST_OVER), last: 1'b1};
			burst_cnt = 2'd1;
		end else begin
			burst[0] = '{opcode: OP_LDA, operand_is_temp: ent[1].is_temp,
			             operand_value: ent[1].value, status: ST_OK, last: 1'b0};
			burst_cnt = 2'(BURST_LEN);
		end
		burst[1] = '{opcode: op_code, operand_is_temp: ent[0].is_temp,
		             operand_value: ent[0].value, status: ST_OK, last: 1'b0};
		burst[2] = '{opcode: OP_STA, operand_is_temp: 1'b1, operand_value: tc_new,
		             status: ST_OK, last: 1'b1};
	end

	pfac_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && has_words),
		.load_words (burst),
		.load_cnt   (burst_cnt),
		.free       (free),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_word  (code_word)
	);

	`PFAC_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DEPTH_W'(STACK_DEPTH),
		"stack depth beyond capacity")
	`PFAC_ASSERT_IMP(a_error_last, code_valid && (code_word.status != ST_OK),
		code_word.last && (code_word.opcode == OP_LDA), "error word not a single last LDA")
	`PFAC_ASSERT_NXT(a_comb_burst, comb, code_valid && (code_word.opcode == OP_LDA)
		&& !code_word.last && (code_word.status == ST_OK), "operator burst not started")
	`PFAC_ASSERT_NXT(a_temp_count, comb, tc_q == $past(tc_new), "temporary counter not advanced")

endmodule
`default_nettype wire

// File: hdl/pfac_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pfac_cell
	import pfac_pkg::*;
(
	input  wire        clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     prev,
	input  entry_t     next,
	output entry_t     entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.take_prev) begin
			entry_q <= prev;
		end else if (ctrl.take_next) begin
			entry_q <= next;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// File: hdl/pfac_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module pfac_emit
	import pfac_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        load,
	input  code_word_t load_words [BURST_LEN],
	input  wire  [1:0] load_cnt,
	output logic       free,
	output logic       code_valid,
	input  wire        code_stall,
	output code_word_t code_word
);

	logic [1:0] cnt_q;
	code_word_t words_q [BURST_LEN];
	logic take;

	assign code_valid = (cnt_q != 2'd0);
	assign take = code_valid && !code_stall;
	assign free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
	assign code_word = words_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// advance the burst one word per take
	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= load_words;
		end else if (take) begin
			for (int i = 0; i < BURST_LEN - 1; i++) begin
				words_q[i] <= words_q[i + 1];
			end
		end
	end

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pfac_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 30;
	localparam int CHAIN_OPS = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sym_valid = 1'b0;
	sym_word_t sym_word = '0;
	logic code_stall = 1'b0;
	logic sym_stall;
	logic code_valid;
	code_word_t code_word;

	sym_word_t symbol_queue[$];
	code_word_t pending_code[$];
	int n_queued = 0;
	int n_taken = 0;
	int n_errors = 0;
	int n_words = 0;
	logic calm = 1'b0;

	entry_t operand_stack [STACK_DEPTH];
	int stack_depth = 0;
	logic [7:0] temp_count = '0;

	postfix_to_accumulator_code u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym_word(sym_word),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_word(code_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic is_operator(input logic [7:0] s);
		return s == CH_PLUS || s == CH_MINUS || s == CH_STAR || s == CH_SLASH;
	endfunction

	function automatic void push_code(input opcode_t op, input entry_t e, input status_t st,
			input logic fin);
		code_word_t c;
		c.opcode = op;
		c.operand_is_temp = e.is_temp;
		c.operand_value = e.value;
		c.status = st;
		c.last = fin;
		pending_code.push_back(c);
	endfunction

	// expected code words for one accepted symbol word
	function automatic void translate_symbol(input sym_word_t w);
		opcode_t op;
		entry_t lhs;
		entry_t rhs;
		entry_t tmp;
		if (w.first) begin
			stack_depth = 0;
			temp_count = '0;
		end
		case (w.symbol)
			CH_PLUS: op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR: op = OP_MUL;
			default: op = OP_DIV;
		endcase
		if (!is_operator(w.symbol)) begin
			if (stack_depth >= STACK_DEPTH) begin
				push_code(OP_LDA, '0, ST_OVER, 1'b1);
			end else begin
				operand_stack[stack_depth] = '{1'b0, w.symbol};
				stack_depth++;
			end
		end else if (stack_depth < 2) begin
			push_code(OP_LDA, '0, ST_UNDER, 1'b1);
		end else begin
			rhs = operand_stack[stack_depth - 1];
			lhs = operand_stack[stack_depth - 2];
			stack_depth -= 2;
			temp_count = temp_count + 8'd1;
			tmp = '{1'b1, temp_count};
			push_code(OP_LDA, lhs, ST_OK, 1'b0);
			push_code(op, rhs, ST_OK, 1'b0);
			push_code(OP_STA, tmp, ST_OK, 1'b1);
			operand_stack[stack_depth] = tmp;
			stack_depth++;
		end
	endfunction

	task automatic add_symbol(input logic [7:0] s, input logic f);
		sym_word_t w;
		w.symbol = s;
		w.first = f;
		symbol_queue.push_back(w);
		n_queued++;
	endtask

	function automatic logic [7:0] random_operand();
		logic [7:0] s;
		do s = 8'($urandom_range(0, 255)); while (is_operator(s));
		return s;
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// well-formed expression with random content, starting a fresh stack
	task automatic add_expression();
		int len;
		int d;
		int n;
		len = $urandom_range(3, 24);
		d = 0;
		for (n = 0; n < len; n++) begin
			if (d >= STACK_DEPTH || (d >= 2 && $urandom_range(0, 2) != 0)) begin
				add_symbol(random_operator(), 1'b0);
				d--;
			end else begin
				add_symbol(random_operand(), n == 0);
				d++;
			end
		end
		while (d > 1) begin
			add_symbol(random_operator(), 1'b0);
			d--;
		end
	endtask

	task automatic add_noise();
		int n;
		for (n = $urandom_range(1, 6); n > 0; n--) begin
			add_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
		end
	endtask

	task automatic add_random(input int count);
		int target;
		target = n_queued + count;
		while (n_queued < target) begin
			if ($urandom_range(0, 4) == 0) begin
				add_noise();
			end else begin
				add_expression();
			end
		end
	endtask

	task automatic report_error(input string msg);
		n_errors++;
		if (n_errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	initial begin
		int i;
		add_symbol(CH_PLUS, 1'b1);
		add_symbol(8'h00, 1'b0);
		add_symbol(CH_MINUS, 1'b0);
		add_symbol(8'hFF, 1'b0);
		add_symbol(CH_MINUS, 1'b0);
		add_symbol("c", 1'b0);
		add_symbol(CH_STAR, 1'b0);
		add_symbol("d", 1'b0);
		add_symbol(CH_SLASH, 1'b0);
		add_symbol("e", 1'b0);
		add_symbol(CH_PLUS, 1'b0);
		for (i = 1; i < STACK_DEPTH; i++) begin
			add_symbol(random_operand(), 1'b0);
		end
		add_symbol(8'h80, 1'b0);
		add_random(RANDOM_ITEMS);
		// long operator chain on one stack
		add_symbol("a", 1'b1);
		for (i = 0; i < CHAIN_OPS; i++) begin
			add_symbol(random_operand(), 1'b0);
			add_symbol(random_operator(), 1'b0);
		end
		add_random(RANDOM_ITEMS);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(posedge clk); while (n_taken != n_queued || pending_code.size() != 0);
		repeat (20) @(posedge clk);
		if (pending_code.size() != 0) begin
			report_error($sformatf("%0d code words never arrived", pending_code.size()));
		end
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// symbol word driver
	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			sym_valid <= 1'b0;
			sym_word <= '0;
			gap = 0;
		end else begin
			if (sym_valid && !sym_stall) begin
				translate_symbol(sym_word);
				n_taken++;
			end
			if (!sym_valid || !sym_stall) begin
				if (gap > 0) begin
					gap--;
					sym_valid <= 1'b0;
				end else if (symbol_queue.size() == 0) begin
					sym_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					gap = $urandom_range(0, 15);
					sym_valid <= 1'b0;
				end else begin
					sym_word <= symbol_queue.pop_front();
					sym_valid <= 1'b1;
				end
			end
			calm <= symbol_queue.size() <= 40;
		end
	end

	// code word monitor
	always @(posedge clk or negedge arst_n) begin
		int hold;
		code_word_t want;
		if (!arst_n) begin
			code_stall <= 1'b0;
			hold = 0;
		end else begin
			if (code_valid && !code_stall) begin
				n_words++;
				if (pending_code.size() == 0) begin
					report_error($sformatf("unexpected code word %0d: op=%0d tmp=%b val=%h st=%0d last=%b",
						n_words, code_word.opcode, code_word.operand_is_temp,
						code_word.operand_value, code_word.status, code_word.last));
				end else begin
					want = pending_code.pop_front();
					if (code_word.opcode !== want.opcode
							|| code_word.operand_is_temp !== want.operand_is_temp
							|| code_word.operand_value !== want.operand_value
							|| code_word.status !== want.status
							|| code_word.last !== want.last) begin
						report_error($sformatf({"code word %0d: expected op=%0d tmp=%b val=%h st=%0d ",
							"last=%b, got op=%0d tmp=%b val=%h st=%0d last=%b"}, n_words,
							want.opcode, want.operand_is_temp, want.operand_value, want.status,
							want.last, code_word.opcode, code_word.operand_is_temp,
							code_word.operand_value, code_word.status, code_word.last));
					end
				end
			end
			if (hold > 0) begin
				hold--;
				code_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(0, 15);
				code_stall <= 1'b1;
			end else begin
				code_stall <= 1'b0;
			end
		end
	end

	// abort when no word moves on either side for too long
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (sym_valid && !sym_stall) || (code_valid && !code_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
